// ===== design/balance_lqr_turn_controller_top_defines.svh =====
// Assertion macros used by the balance controller top.
`ifndef BALANCE_LQR_TURN_CONTROLLER_TOP_DEFINES_SVH
`define BALANCE_LQR_TURN_CONTROLLER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define BLTC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define BLTC_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("reset assertion failed");
`else
`define BLTC_ASSERT(lbl, prop)
`define BLTC_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== design/bltc_pkg.sv =====
package bltc_pkg;

    localparam int LIFT_TICKS = 1500;
    localparam logic signed [31:0] PITCH_OFFSET = 32'sd1966;
    localparam logic signed [31:0] LIFT_SPEED   = 32'sd11796480;

    // ceil(2^43 / 3125) and ceil(2^35 / 25) for reciprocal division
    localparam logic [31:0] RECIP_3125 = 32'd2814749768;
    localparam logic [30:0] RECIP_25   = 31'd1374389535;

    localparam logic [2:0] CFG_GAIN_POSITION   = 3'd0;
    localparam logic [2:0] CFG_GAIN_SPEED      = 3'd1;
    localparam logic [2:0] CFG_GAIN_PITCH      = 3'd2;
    localparam logic [2:0] CFG_GAIN_PITCH_RATE = 3'd3;
    localparam logic [2:0] CFG_TURN_KP         = 3'd4;
    localparam logic [2:0] CFG_TURN_KD         = 3'd5;
    localparam logic [2:0] CFG_PITCH_RATE_TGT  = 3'd6;
    localparam logic [2:0] CFG_TORQUE_LIMIT    = 3'd7;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_ANGLE = 2'd1;
    localparam logic [1:0] CMD_RATE  = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    localparam logic [2:0] TERM_POS    = 3'd0;
    localparam logic [2:0] TERM_SPEED  = 3'd1;
    localparam logic [2:0] TERM_PITCH  = 3'd2;
    localparam logic [2:0] TERM_PRATE  = 3'd3;
    localparam logic [2:0] TERM_TURN_A = 3'd4;
    localparam logic [2:0] TERM_TURN_B = 3'd5;
    localparam logic [2:0] TERM_SCALE  = 3'd6;

    typedef enum logic [1:0] {DIV_POS, DIV_SPEED, DIV_SCALE} t_div_kind;

    typedef enum logic [3:0] {
        S_IDLE, S_POSDIV, S_POSWAIT, S_VDIV, S_VWAIT, S_MUL, S_ACC,
        S_MIX, S_CHK, S_SMUL, S_SDIV, S_SWAIT, S_DONE
    } t_state;

    typedef struct packed {
        logic      latch;
        logic      div_start;
        t_div_kind div_kind;
        logic      pos_upd;
        logic      v_upd;
        logic      mul_go;
        logic      acc_go;
        logic [2:0] idx;
        logic      mix;
        logic      scale_upd;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic need_scale;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)       return 32'sh7fffffff;
        else if (x < -64'sd2147483648) return 32'sh80000000;
        else                           return x[31:0];
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] d;
        d = {{32{a[31]}}, a} - {{32{b[31]}}, b};
        return sat32(d);
    endfunction

endpackage

// ===== design/bltc_div.sv =====
module bltc_div import bltc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic [63:0] o_quot
);
    logic [63:0] r_q;
    logic [31:0] r_r, r_d;
    logic [6:0]  r_cnt;
    logic [32:0] rem_sh, rem_sub;

    // one quotient bit per cycle, restoring
    always_comb begin
        rem_sh  = {r_r, r_q[63]};
        rem_sub = rem_sh - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 7'd0;
        end else if (i_start) begin
            r_cnt <= 7'd64;
        end else if (r_cnt != 7'd0) begin
            r_cnt <= r_cnt - 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= 32'd0;
            r_d <= i_divisor;
        end else if (r_cnt != 7'd0) begin
            if (!rem_sub[32]) begin
                r_r <= rem_sub[31:0];
                r_q <= {r_q[62:0], 1'b1};
            end else begin
                r_r <= rem_sh[31:0];
                r_q <= {r_q[62:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != 7'd0);
    assign o_quot = r_q;
endmodule

// ===== design/bltc_ctrl.sv =====
module bltc_ctrl import bltc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;
    logic [2:0] r_idx, n_idx;
    logic r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= TERM_POS;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.div_kind = DIV_POS;
        o_cmd.idx   = r_idx;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_POSDIV;
                end
            end
            S_POSDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_kind  = DIV_POS;
                n_state = S_POSWAIT;
            end
            S_POSWAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.pos_upd = 1'b1;
                    n_state = S_VDIV;
                end
            end
            S_VDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_kind  = DIV_SPEED;
                n_state = S_VWAIT;
            end
            S_VWAIT: begin
                o_cmd.div_kind = DIV_SPEED;
                if (!i_stat.div_busy) begin
                    o_cmd.v_upd = 1'b1;
                    n_idx   = TERM_POS;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_go = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_go = 1'b1;
                if (r_idx == TERM_TURN_B) begin
                    n_state = S_MIX;
                end else begin
                    n_idx   = r_idx + 3'd1;
                    n_state = S_MUL;
                end
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                n_state = i_stat.need_scale ? S_SMUL : S_DONE;
            end
            S_SMUL: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.idx    = TERM_SCALE;
                n_state = S_SDIV;
            end
            S_SDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_kind  = DIV_SCALE;
                n_state = S_SWAIT;
            end
            S_SWAIT: begin
                o_cmd.div_kind = DIV_SCALE;
                if (!i_stat.div_busy) begin
                    o_cmd.scale_upd = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
endmodule

// ===== design/bltc_dp.sv =====
module bltc_dp import bltc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata,
    input  logic [287:0] i_in_data,
    input  logic [2:0]   i_in_user,
    input  t_cmd         i_cmd,
    output t_stat        o_stat,
    output logic [95:0]  o_out_data,
    output logic [1:0]   o_out_user
);
    logic signed [31:0] r_gpos, r_gspd, r_gpit, r_gprt, r_kp, r_kd, r_prt;
    logic [30:0] r_lim;
    logic signed [31:0] r_pitch, r_prate, r_yawt, r_yawr, r_wl, r_wr, r_post, r_spdt;
    logic signed [31:0] r_position, r_tt, r_v, r_left, r_right;
    logic [10:0] r_lift_count;
    logic r_run, r_rate, r_lifted;
    logic signed [63:0] r_prod;
    logic signed [41:0] r_t, r_turn;
    logic signed [31:0] r_o_tl, r_o_tr, r_o_cs;
    logic r_o_run, r_o_lift;
    logic [31:0] r_rq;

    logic signed [32:0] d;
    logic signed [38:0] nx, n;
    logic [38:0] n_abs, n_round, q_1600;
    logic [27:0] rp_y;
    logic [30:0] rv_x;
    logic [59:0] rp_prod;
    logic [61:0] rv_prod;
    logic [63:0] div_q, prod_abs;
    logic [31:0] den_abs;
    logic div_busy, div_go, rem_nz;
    logic signed [31:0] ma, mb, lim, nlim, num, den, factor;
    logic signed [41:0] term;
    logic signed [63:0] lsum, rsum, qs, pos_sum, delta, q64;
    logic lo, hi, l_lt_r, scale_left, over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpos <= -32'sd342460;
            r_gspd <= -32'sd1616559;
            r_gpit <= -32'sd11058313;
            r_gprt <= -32'sd536425;
            r_kp   <= 32'sd503316;
            r_kd   <= 32'sd2013266;
            r_prt  <= 32'sd0;
            r_lim  <= 31'd6554;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_GAIN_POSITION:   r_gpos <= i_cfg_wdata;
                CFG_GAIN_SPEED:      r_gspd <= i_cfg_wdata;
                CFG_GAIN_PITCH:      r_gpit <= i_cfg_wdata;
                CFG_GAIN_PITCH_RATE: r_gprt <= i_cfg_wdata;
                CFG_TURN_KP:         r_kp   <= i_cfg_wdata;
                CFG_TURN_KD:         r_kd   <= i_cfg_wdata;
                CFG_PITCH_RATE_TGT:  r_prt  <= i_cfg_wdata;
                CFG_TORQUE_LIMIT:    r_lim  <= i_cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // wheel difference times 27, as shifts and adds
    // divide by 1600 as a shift by 6 then by 25, by 1600000 as a shift by 9
    // then by 3125, each through a reciprocal product
    always_comb begin
        d       = {r_wr[31], r_wr} - {r_wl[31], r_wl};
        nx      = {{6{d[32]}}, d};
        n       = (nx <<< 4) + (nx <<< 3) + (nx <<< 1) + nx;
        n_abs   = n[38] ? 39'(-n) : n;
        n_round = n_abs + 39'd800000;
        rp_y    = n_round[36:9];
        rv_x    = n_abs[36:6];
        rp_prod = 60'(rp_y) * 60'(RECIP_3125);
        rv_prod = 62'(rv_x) * 62'(RECIP_25);
        div_go  = i_cmd.div_start && (i_cmd.div_kind == DIV_SCALE);
    end

    bltc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (prod_abs),
        .i_divisor  (den_abs),
        .o_busy     (div_busy),
        .o_quot     (div_q)
    );

    // torque limiting choice
    always_comb begin
        lim        = {1'b0, r_lim};
        nlim       = -lim;
        lo         = (r_left < nlim) || (r_right < nlim);
        hi         = (r_left > lim) || (r_right > lim);
        l_lt_r     = r_left < r_right;
        scale_left = lo ? !l_lt_r : l_lt_r;
        num        = scale_left ? r_left : r_right;
        den        = scale_left ? r_right : r_left;
        factor     = lo ? nlim : lim;
        prod_abs   = r_prod[63] ? 64'(-r_prod) : r_prod;
        den_abs    = den[31] ? 32'(-den) : den;
        qs         = (r_prod[63] ^ den[31]) ? 64'(-div_q) : div_q;
    end

    always_comb begin
        case (i_cmd.idx)
            TERM_POS:    begin ma = sat_sub(r_post, r_position); mb = r_gpos; end
            TERM_SPEED:  begin ma = sat_sub(r_spdt, r_v);        mb = r_gspd; end
            TERM_PITCH:  begin ma = sat_sub(PITCH_OFFSET, r_pitch); mb = r_gpit; end
            TERM_PRATE:  begin ma = sat_sub(r_prt, r_prate);     mb = r_gprt; end
            TERM_TURN_A: begin
                ma = r_rate ? sat_sub(r_tt, r_yawr) : sat_sub(r_tt, r_yawt);
                mb = r_rate ? r_kd : r_kp;
            end
            TERM_TURN_B: begin ma = r_rate ? 32'sd0 : r_yawr; mb = r_kd; end
            TERM_SCALE:  begin ma = num; mb = factor; end
            default:     begin ma = 32'sd0; mb = 32'sd0; end
        endcase
        term    = {{2{r_prod[63]}}, r_prod[63:24]};
        lsum    = -{{22{r_t[41]}}, r_t} - {{22{r_turn[41]}}, r_turn};
        rsum    = {{22{r_t[41]}}, r_t} - {{22{r_turn[41]}}, r_turn};
        q64     = {32'd0, r_rq};
        q_1600  = ({7'd0, r_rq} << 10) + ({7'd0, r_rq} << 9) + ({7'd0, r_rq} << 6);
        rem_nz  = (n_abs != q_1600);
        delta   = n[38] ? -q64 : q64;
        pos_sum = {{32{r_position[31]}}, r_position} + delta;
        over    = (r_wl > LIFT_SPEED) || (r_wl < -LIFT_SPEED) ||
                  (r_wr > LIFT_SPEED) || (r_wr < -LIFT_SPEED);
    end

    // control state of the loop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run        <= 1'b0;
            r_rate       <= 1'b0;
            r_lift_count <= 11'd0;
            r_position   <= 32'sd0;
            r_tt         <= 32'sd0;
            r_lifted     <= 1'b0;
        end else begin
            if (i_cmd.latch) begin
                r_lifted <= 1'b0;
                case (i_in_user[2:1])
                    CMD_ANGLE: begin r_run <= 1'b1; r_rate <= 1'b0; end
                    CMD_RATE:  begin r_run <= 1'b1; r_rate <= 1'b1; end
                    CMD_STOP:  r_run <= 1'b0;
                    default: ;
                endcase
                if (i_in_user[0]) r_tt <= i_in_data[287:256];
            end
            if (i_cmd.pos_upd) begin
                r_position <= sat32(pos_sum);
                if (over) begin
                    if (r_lift_count >= 11'(LIFT_TICKS)) begin
                        r_lift_count <= 11'd0;
                        r_run    <= 1'b0;
                        r_rate   <= 1'b0;
                        r_lifted <= 1'b1;
                    end else begin
                        r_lift_count <= r_lift_count + 11'd1;
                    end
                end else begin
                    r_lift_count <= 11'd0;
                end
            end
            if (i_cmd.out_load && !r_run) r_tt <= r_yawt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_pitch <= i_in_data[31:0];
            r_prate <= i_in_data[63:32];
            r_yawt  <= i_in_data[95:64];
            r_yawr  <= i_in_data[127:96];
            r_wl    <= i_in_data[159:128];
            r_wr    <= i_in_data[191:160];
            r_post  <= i_in_data[223:192];
            r_spdt  <= i_in_data[255:224];
            r_t     <= '0;
            r_turn  <= '0;
        end
        if (i_cmd.div_start) begin
            case (i_cmd.div_kind)
                DIV_POS:   r_rq <= {15'd0, rp_prod[59:43]};
                DIV_SPEED: r_rq <= {5'd0, rv_prod[61:35]};
                default: ;
            endcase
        end
        if (i_cmd.v_upd) begin
            r_v <= n[38] ? (32'd0 - r_rq - {31'd0, rem_nz}) : r_rq;
        end
        if (i_cmd.mul_go) r_prod <= ma * mb;
        if (i_cmd.acc_go) begin
            case (i_cmd.idx)
                TERM_TURN_A: r_turn <= r_turn + term;
                TERM_TURN_B: r_turn <= r_turn - term;
                default:     r_t    <= r_t + term;
            endcase
        end
        if (i_cmd.mix) begin
            r_left  <= sat32(lsum);
            r_right <= sat32(rsum);
        end
        if (i_cmd.scale_upd) begin
            if (scale_left) begin
                r_left  <= sat32(qs);
                r_right <= factor;
            end else begin
                r_right <= sat32(qs);
                r_left  <= factor;
            end
        end
        if (i_cmd.out_load) begin
            r_o_tl   <= r_run ? r_left : 32'sd0;
            r_o_tr   <= r_run ? r_right : 32'sd0;
            r_o_cs   <= r_v;
            r_o_run  <= r_run;
            r_o_lift <= r_lifted;
        end
    end

    assign o_stat.div_busy   = div_busy;
    assign o_stat.need_scale = lo || hi;
    assign o_out_data = {r_o_cs, r_o_tr, r_o_tl};
    assign o_out_user = {r_o_lift, r_o_run};
endmodule

// ===== design/balance_lqr_turn_controller_top.sv =====
// A torque pair that needs proportional limiting also takes one 64-step
// serial divide before the result is valid.
// The block takes a new item only when idle; the sequencer steps (two
// reciprocal divides, six shared gain products, the limiter) run per item.
// Reset: synchronous, active low; clears loop state and loads register defaults.
`include "balance_lqr_turn_controller_top_defines.svh"
module balance_lqr_turn_controller_top import bltc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // items in
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // pitch, pitch_rate, yaw_total, yaw_rate, wheel_speed_left,
    // wheel_speed_right, position_target, speed_target, turn_target_value
    input  logic [287:0] i_s_axis_tdata,
    // turn_target_load, command[1:0]
    input  logic [2:0]   i_s_axis_tuser,
    // results out
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // torque_left, torque_right, chassis_speed
    output logic [95:0]  o_m_axis_tdata,
    // running, lift_detected
    output logic [1:0]   o_m_axis_tuser,
    // register writes
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata
);
    t_cmd  cmd;
    t_stat stat;

    // sequencer: walks the divides, the six gain products and the limiter
    bltc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath: registers, shared multiplier, serial divider, output hold
    bltc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser)
    );

    // stopped results carry zero torque
    `BLTC_ASSERT(a_stop_zero, o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata[63:0] == 64'd0)
    // a lift always stops the block
    `BLTC_ASSERT(a_lift_stop, o_m_axis_tvalid && o_m_axis_tuser[1] |-> !o_m_axis_tuser[0])
    // hold off new items while one is at work
    `BLTC_ASSERT(a_one_item, i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
endmodule

// ===== tb/sv/balance_lqr_turn_controller_top_tb.sv =====
module balance_lqr_turn_controller_top_tb;
    import bltc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;   // cycles without any accepted item
    localparam int DRAIN_CYCLES = 260;    // extra idle wait after the result queue empties
    localparam int RANDOM_PER_SETTING = 250;

    // One control tick of sensor data and commands.
    typedef struct {
        logic signed [31:0] pitch, pitch_rate, yaw_total, yaw_rate;
        logic signed [31:0] wheel_l, wheel_r, pos_tgt, spd_tgt, turn_val;
        logic               turn_load;
        logic [1:0]         cmd;
    } t_tick;

    // Wheel torque pair and flags produced by one tick.
    typedef struct {
        logic signed [31:0] torque_l, torque_r;
        logic               running, lifted;
        logic signed [31:0] chassis_v;
    } t_torque;

    typedef struct {
        t_tick   stim;
        bit      fixed;    // expected torques typed in below instead of predicted
        t_torque want;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [287:0] i_s_axis_tdata = '0;
    logic [2:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [95:0]  o_m_axis_tdata;
    logic [1:0]   o_m_axis_tuser;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_addr = '0;
    logic [31:0]  i_cfg_wdata = '0;

    balance_lqr_turn_controller_top DUT (.*);

    always #5 i_clk = ~i_clk;

    // Predictor copy of the controller registers and loop state.
    longint k_pos, k_spd, k_pitch, k_prate, k_turn_p, k_turn_d, prate_tgt, t_limit;
    longint position, turn_target;
    int     lift_count;
    bit     run_flag, rate_mode;

    t_torque torque_q[$];
    int      errors = 0;
    int      quiet_cycles = 0;
    bit      no_idle = 1'b0;

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Saturate the error, multiply by a Q8.24 gain, floor back to Q16.16.
    function automatic longint gain_term(longint err, longint gain);
        return (sat32(err) * gain) >>> 24;
    endfunction

    function automatic void load_defaults();
        k_pos = -342460; k_spd = -1616559; k_pitch = -11058313; k_prate = -536425;
        k_turn_p = 503316; k_turn_d = 2013266; prate_tgt = 0; t_limit = 6554;
        position = 0; turn_target = 0; lift_count = 0; run_flag = 0; rate_mode = 0;
    endfunction

    function automatic void track_cfg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            CFG_GAIN_POSITION:   k_pos = longint'($signed(val));
            CFG_GAIN_SPEED:      k_spd = longint'($signed(val));
            CFG_GAIN_PITCH:      k_pitch = longint'($signed(val));
            CFG_GAIN_PITCH_RATE: k_prate = longint'($signed(val));
            CFG_TURN_KP:         k_turn_p = longint'($signed(val));
            CFG_TURN_KD:         k_turn_d = longint'($signed(val));
            CFG_PITCH_RATE_TGT:  prate_tgt = longint'($signed(val));
            default:             t_limit = longint'({33'd0, val[30:0]});
        endcase
    endfunction

    // Advance the controller by one tick and return its torque pair.
    function automatic t_torque control_tick(t_tick s);
        t_torque r;
        longint wl, wr, n, v, delta, t, turn, left, right, lim;
        bit lifted;
        lifted = 0;
        if (s.cmd == CMD_ANGLE) begin
            run_flag = 1; rate_mode = 0;
        end else if (s.cmd == CMD_RATE) begin
            run_flag = 1; rate_mode = 1;
        end else if (s.cmd == CMD_STOP) begin
            run_flag = 0;
        end
        if (s.turn_load) turn_target = s.turn_val;
        wl = s.wheel_l;
        wr = s.wheel_r;
        n = (wr - wl) * 27;
        v = n / 1600;
        if (n < 0 && (n % 1600) != 0) v--;
        if (n >= 0) delta = (n + 800000) / 1600000;
        else delta = -((-n + 800000) / 1600000);
        position = sat32(position + delta);
        if (wl > LIFT_SPEED || wl < -LIFT_SPEED || wr > LIFT_SPEED || wr < -LIFT_SPEED) begin
            if (lift_count >= LIFT_TICKS) begin
                lift_count = 0; run_flag = 0; rate_mode = 0; lifted = 1;
            end else begin
                lift_count++;
            end
        end else begin
            lift_count = 0;
        end
        t = gain_term(longint'(s.pos_tgt) - position, k_pos)
          + gain_term(longint'(s.spd_tgt) - v, k_spd)
          + gain_term(longint'(PITCH_OFFSET) - s.pitch, k_pitch)
          + gain_term(prate_tgt - s.pitch_rate, k_prate);
        if (rate_mode)
            turn = gain_term(turn_target - s.yaw_rate, k_turn_d);
        else
            turn = gain_term(turn_target - s.yaw_total, k_turn_p)
                 - gain_term(longint'(s.yaw_rate), k_turn_d);
        left = sat32(-t - turn);
        right = sat32(t - turn);
        lim = t_limit;
        // Scale the pair in proportion around whichever wheel breaks the bound.
        if (left < -lim || right < -lim) begin
            if (left < right) begin
                right = (right * -lim) / left; left = -lim;
            end else begin
                left = (left * -lim) / right; right = -lim;
            end
        end else if (left > lim || right > lim) begin
            if (left < right) begin
                left = (left * lim) / right; right = lim;
            end else begin
                right = (right * lim) / left; left = lim;
            end
        end
        left = sat32(left);
        right = sat32(right);
        if (!run_flag) begin
            left = 0; right = 0; turn_target = s.yaw_total;
        end
        r.torque_l = left[31:0];
        r.torque_r = right[31:0];
        r.running = run_flag;
        r.lifted = lifted;
        r.chassis_v = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] rnd_small(int unsigned span);
        return $urandom_range(span * 2) - span;
    endfunction

    function automatic logic [31:0] rnd_edge();
        case ($urandom_range(6))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'hffffffff;
            4: return LIFT_SPEED;
            5: return LIFT_SPEED + 1;
            default: return -(LIFT_SPEED + 1);
        endcase
    endfunction

    // Mostly plausible ticks of a running robot, some noise and some edges.
    function automatic t_tick random_tick();
        t_tick s;
        int kind;
        kind = $urandom_range(99);
        if (kind < 70) begin
            s.pitch = rnd_small(40000); s.pitch_rate = rnd_small(200000);
            s.yaw_total = rnd_small(400000); s.yaw_rate = rnd_small(200000);
            s.wheel_l = rnd_small(11141120); s.wheel_r = rnd_small(11141120);
            s.pos_tgt = rnd_small(100000); s.spd_tgt = rnd_small(100000);
            s.turn_val = rnd_small(400000);
            s.turn_load = ($urandom_range(9) == 0);
            case ($urandom_range(19))
                0: s.cmd = CMD_STOP;
                1, 2: s.cmd = CMD_ANGLE;
                3, 4: s.cmd = CMD_RATE;
                default: s.cmd = CMD_NONE;
            endcase
        end else if (kind < 90) begin
            s.pitch = $urandom; s.pitch_rate = $urandom; s.yaw_total = $urandom;
            s.yaw_rate = $urandom; s.wheel_l = $urandom; s.wheel_r = $urandom;
            s.pos_tgt = $urandom; s.spd_tgt = $urandom; s.turn_val = $urandom;
            s.turn_load = 1'($urandom_range(1));
            s.cmd = 2'($urandom_range(3));
        end else begin
            s.pitch = rnd_edge(); s.pitch_rate = rnd_edge(); s.yaw_total = rnd_edge();
            s.yaw_rate = rnd_edge(); s.wheel_l = rnd_edge(); s.wheel_r = rnd_edge();
            s.pos_tgt = rnd_edge(); s.spd_tgt = rnd_edge(); s.turn_val = rnd_edge();
            s.turn_load = 1'($urandom_range(1));
            s.cmd = 2'($urandom_range(3));
        end
        return s;
    endfunction

    function automatic t_tick uniform_tick(logic [31:0] val, logic load, logic [1:0] cmd);
        t_tick s;
        s.pitch = val; s.pitch_rate = val; s.yaw_total = val; s.yaw_rate = val;
        s.wheel_l = val; s.wheel_r = val; s.pos_tgt = val; s.spd_tgt = val;
        s.turn_val = val; s.turn_load = load; s.cmd = cmd;
        return s;
    endfunction

    task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_wdata = val;
        track_cfg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Wait until every torque pair has come back, then let the block go idle.
    task automatic drain();
        while (torque_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Present one tick, hold it until accepted, record its expected torques.
    task automatic send_tick(t_tick s, bit fixed, t_torque want);
        t_torque got;
        while (!no_idle && $urandom_range(99) < 25) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tdata = {s.turn_val, s.spd_tgt, s.pos_tgt, s.wheel_r, s.wheel_l,
                          s.yaw_rate, s.yaw_total, s.pitch_rate, s.pitch};
        i_s_axis_tuser = {s.cmd, s.turn_load};
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        got = control_tick(s);
        torque_q.push_back(fixed ? want : got);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    // Result side: random back-pressure, compare each accepted pair in order.
    always @(negedge i_clk)
        i_m_axis_tready = no_idle || ($urandom_range(99) >= 25);

    always @(posedge i_clk) begin
        t_torque w;
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (torque_q.size() == 0) begin
                $error("unexpected result item, tdata %h", o_m_axis_tdata);
                errors++;
            end else begin
                w = torque_q.pop_front();
                if (o_m_axis_tdata[31:0] !== w.torque_l) begin
                    $error("torque_left: expected %0d, actual %0d",
                           w.torque_l, $signed(o_m_axis_tdata[31:0]));
                    errors++;
                end
                if (o_m_axis_tdata[63:32] !== w.torque_r) begin
                    $error("torque_right: expected %0d, actual %0d",
                           w.torque_r, $signed(o_m_axis_tdata[63:32]));
                    errors++;
                end
                if (o_m_axis_tdata[95:64] !== w.chassis_v) begin
                    $error("chassis_speed: expected %0d, actual %0d",
                           w.chassis_v, $signed(o_m_axis_tdata[95:64]));
                    errors++;
                end
                if (o_m_axis_tuser[0] !== w.running) begin
                    $error("running: expected %0d, actual %0d", w.running, o_m_axis_tuser[0]);
                    errors++;
                end
                if (o_m_axis_tuser[1] !== w.lifted) begin
                    $error("lift_detected: expected %0d, actual %0d",
                           w.lifted, o_m_axis_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_row    rows[$];
        t_row    r;
        t_torque zero_pair;
        logic [31:0] v;

        load_defaults();
        zero_pair = '{32'sd0, 32'sd0, 1'b0, 1'b0, 32'sd0};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed table: stopped after reset, wheel-speed sign, both modes,
        // field extremes, the over-speed threshold, torque scaling and stop.
        r.fixed = 1; r.want = zero_pair;
        r.stim = uniform_tick(32'd0, 1'b0, CMD_NONE);
        rows.push_back(r);
        r.stim.wheel_r = 1600; r.want.chassis_v = 27;
        rows.push_back(r);
        r.stim.wheel_r = 0; r.stim.wheel_l = 1600; r.want.chassis_v = -27;
        rows.push_back(r);
        r.fixed = 0;
        r.stim = uniform_tick(32'd0, 1'b0, CMD_ANGLE);
        rows.push_back(r);
        r.stim = uniform_tick(32'd0, 1'b1, CMD_RATE); r.stim.turn_val = 32'h7fffffff;
        rows.push_back(r);
        r.stim = uniform_tick(32'h7fffffff, 1'b0, CMD_ANGLE);
        rows.push_back(r);
        r.stim = uniform_tick(32'h80000000, 1'b1, CMD_RATE);
        rows.push_back(r);
        r.stim = uniform_tick(32'hffffffff, 1'b1, CMD_NONE);
        rows.push_back(r);
        // At the over-speed threshold exactly, then just past it.
        r.stim = uniform_tick(32'd0, 1'b0, CMD_ANGLE);
        r.stim.wheel_l = LIFT_SPEED; r.stim.wheel_r = -LIFT_SPEED;
        rows.push_back(r);
        r.stim.wheel_l = LIFT_SPEED + 1;
        rows.push_back(r);
        r.stim.wheel_l = 0; r.stim.wheel_r = -(LIFT_SPEED + 1);
        rows.push_back(r);
        // Large pitch both ways drives the torques past the bound.
        r.stim = uniform_tick(32'd0, 1'b0, CMD_ANGLE); r.stim.pitch = 32'h00080000;
        rows.push_back(r);
        r.stim.pitch = 32'hfff80000;
        rows.push_back(r);
        r.stim = uniform_tick(32'd0, 1'b1, CMD_ANGLE);
        r.stim.yaw_total = 32'h00040000; r.stim.yaw_rate = 32'hfffc0000;
        rows.push_back(r);
        r.stim.cmd = CMD_RATE;
        rows.push_back(r);
        r.fixed = 1; r.want = zero_pair;
        r.stim = uniform_tick(32'd0, 1'b0, CMD_STOP);
        rows.push_back(r);
        r.fixed = 0;
        r.stim = uniform_tick(32'h00012345, 1'b1, CMD_NONE);
        rows.push_back(r);
        r.stim.cmd = CMD_ANGLE;
        rows.push_back(r);

        foreach (rows[i]) send_tick(rows[i].stim, rows[i].fixed, rows[i].want);

        // Random part under several register settings, extremes among them.
        for (int phase = 0; phase < 5; phase++) begin
            drain();
            for (int idx = 0; idx < 8; idx++) begin
                case (phase)
                    0: v = (idx == CFG_TORQUE_LIMIT) ? $urandom_range(200000)
                                                     : rnd_small(20000000);
                    1: v = 32'h7fffffff;
                    2: v = (idx == CFG_TORQUE_LIMIT) ? 32'd0 : 32'h80000000;
                    3: v = (idx == CFG_TORQUE_LIMIT) ? 32'h7fffffff : $urandom;
                    default: v = $urandom;
                endcase
                write_cfg(idx[2:0], v);
            end
            for (int k = 0; k < RANDOM_PER_SETTING; k++) begin
                no_idle = (phase == 0 && k >= 100 && k < 200);
                send_tick(random_tick(), 0, zero_pair);
            end
            no_idle = 0;
        end

        drain();
        if (errors == 0 && torque_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
